FILE: hdl/bm3_pkg.sv
// Shared types and constants for the 3x3 binary morphology block.
// No dependencies; imported by every module of the block except the generic RAM.
package bm3_pkg;

  // Frame size limits and derived counter widths
  localparam int unsigned MAX_WIDTH  = 2048;
  localparam int unsigned MAX_HEIGHT = 4096;
  localparam int unsigned MIN_DIM    = 3;
  localparam int unsigned COL_W      = $clog2(MAX_WIDTH);
  localparam int unsigned ROW_W      = $clog2(MAX_HEIGHT);

  // Register and payload widths
  localparam int unsigned WID_W      = 12;
  localparam int unsigned HGT_W      = 13;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 13;
  localparam int unsigned PIX_W      = 8;

  // Widths for compares, with headroom for +3 on the position counters
  localparam int unsigned COLX_W = ((COL_W > WID_W) ? COL_W : WID_W) + 2;
  localparam int unsigned ROWX_W = ((ROW_W > HGT_W) ? ROW_W : HGT_W) + 2;

  // Register reset values
  localparam logic [WID_W-1:0] WIDTH_RESET  = WID_W'(640);
  localparam logic [HGT_W-1:0] HEIGHT_RESET = HGT_W'(480);

  // Line memory: per column, the two previous rows ([1] older, [0] newer)
  localparam int unsigned LINE_W = 2;

  // Result queue
  localparam int unsigned OUTQ_DEPTH = 4;
  localparam int unsigned OUTQ_PTR_W = $clog2(OUTQ_DEPTH);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMAGE_WIDTH    = 2'd0,
    CFG_IMAGE_HEIGHT   = 2'd1,
    CFG_OPERATION_MODE = 2'd2
  } cfg_idx_e;

  typedef enum logic {
    ACT_PIXEL = 1'b0,
    ACT_DRAIN = 1'b1
  } action_e;

  typedef enum logic {
    MODE_ERODE  = 1'b0,
    MODE_DILATE = 1'b1
  } mode_e;

  // Request handed from the position stage to the window stage.
  // Mask vectors: index 0 = top row / left column, 2 = bottom row / right column.
  typedef struct packed {
    logic             adv;   // window shifts
    logic             wr;    // pixel written back to the line memory
    logic             fg;    // foreground bit of the new pixel
    logic [COL_W-1:0] addr;  // column of the new pixel
    logic             emit;  // a result is produced
    logic             last;  // result is the bottom-right pixel
    mode_e            mode;
    logic [2:0]       rin;   // neighborhood rows inside the frame
    logic [2:0]       rint;  // neighborhood rows in the interior
    logic [2:0]       cin;   // neighborhood columns inside the frame
    logic [2:0]       cint;  // neighborhood columns in the interior
  } s1_req_t;

  typedef struct packed {
    logic fg;
    logic eof;
  } res_t;

endpackage

FILE: hdl/bm3_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module bm3_ram #(
  parameter  int unsigned WIDTH  = 1,
  parameter  int unsigned DEPTH  = 2,
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

FILE: hdl/bm3_window.sv
// Window stage: merges line-memory data with the new pixel, shifts the 3x3
// window, writes the column back and forms the result. Depends on bm3_pkg.
module bm3_window
  import bm3_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  s1_req_t           req_i,
  input  logic [LINE_W-1:0] line_rdata_i,
  output logic              line_we_o,
  output logic [COL_W-1:0]  line_waddr_o,
  output logic [LINE_W-1:0] line_wdata_o,
  output logic              push_o,
  output res_t              res_o
);

  s1_req_t         req_q;
  logic [2:0][2:0] win_q;
  logic [2:0][2:0] win_d;
  logic [2:0]      new_col;
  logic            all_fg;
  logic            any_int;
  logic            fg_res;

  // request register, lines up with the memory read data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_q <= '0;
    end else begin
      req_q <= req_i;
    end
  end

  // new column: top = two rows back, middle = previous row, bottom = new pixel
  assign new_col = {req_q.fg, line_rdata_i[0], line_rdata_i[1]};
  assign win_d   = {new_col, win_q[2], win_q[1]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= '0;
    end else if (req_q.adv) begin
      win_q <= win_d;
    end
  end

  // write back the two most recent rows of this column
  assign line_we_o    = req_q.wr;
  assign line_waddr_o = req_q.addr;
  assign line_wdata_o = {line_rdata_i[0], req_q.fg};

  // neighborhood reduction with frame and interior masks
  always_comb begin
    logic b;
    all_fg  = 1'b1;
    any_int = 1'b0;
    b       = 1'b0;
    for (int j = 0; j < 3; j++) begin
      for (int i = 0; i < 3; i++) begin
        b       = win_d[j][i] & req_q.rin[i] & req_q.cin[j];
        all_fg  = all_fg & b;
        any_int = any_int | (b & req_q.rint[i] & req_q.cint[j]);
      end
    end
  end

  always_comb begin
    unique case (req_q.mode)
      MODE_ERODE:  fg_res = all_fg & req_q.rint[1] & req_q.cint[1];
      MODE_DILATE: fg_res = any_int;
      default:     fg_res = 1'b0;
    endcase
  end

  assign push_o     = req_q.emit;
  assign res_o.fg   = fg_res;
  assign res_o.eof  = req_q.last;

endmodule

FILE: hdl/bm3_outq.sv
// Small result queue that decouples the output channel from the pipeline.
// Depends on bm3_pkg.
module bm3_outq
  import bm3_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  res_t                  item_i,
  input  logic                  out_stall_i,
  output logic                  out_valid_o,
  output res_t                  item_o,
  output logic [OUTQ_PTR_W:0]   level_o
);

  res_t                  mem_q [OUTQ_DEPTH];
  logic [OUTQ_PTR_W-1:0] wr_ptr_q;
  logic [OUTQ_PTR_W-1:0] rd_ptr_q;
  logic [OUTQ_PTR_W:0]   level_q;
  logic [OUTQ_PTR_W:0]   level_d;
  logic                  pop;

  assign out_valid_o = (level_q != '0);
  assign pop         = out_valid_o && !out_stall_i;
  assign item_o      = mem_q[rd_ptr_q];
  assign level_o     = level_q;

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

  // fill level
  always_comb begin
    unique case ({push_i, pop})
      2'b10:   level_d = level_q + 1'b1;
      2'b01:   level_d = level_q - 1'b1;
      default: level_d = level_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      level_q  <= '0;
    end else begin
      level_q <= level_d;
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
    end
  end

endmodule

FILE: hdl/binary_morphology_3x3_top.sv
// Top level of the 3x3 binary erosion / dilation block.
// Depends on bm3_pkg, bm3_ram, bm3_window and bm3_outq.
//
// Usage:
//  - Input channel (in_valid_i / in_stall_o): one request per cycle, raster order.
//    action_i = pixel carries pixel_value_i (nonzero is foreground); action_i =
//    drain flushes one pending result once the whole frame has been input.
//    Pixels after frame end are dropped until drained; early drains are dropped.
//  - Output channel (out_valid_o / out_stall_i): out_pixel_o is 0 or 255,
//    end_of_frame_o marks the bottom-right pixel. Results trail the input by
//    one line plus one pixel, so width+1 drains close each frame.
//  - A result passes the window request register, then the result queue. While
//    in_stall_o is low the block takes one request per cycle, limited by the
//    single read and single write of the line memory per cycle.
//  - The line memory (2 bits x 2048 columns) holds the two previous rows.
//  - in_stall_o rises when two results are held in the output queue; a
//    stalled receiver therefore backs up the input after two results.
//  - Reset: width 640, height 480, erosion, stream at frame start. The line
//    memory needs no clearing: every entry used is written in the same frame.
//  - Configuration writes (only while idle) to indices 0 to 2 restart the stream position.
module binary_morphology_3x3_top
  import bm3_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic                  action_i,
  input  logic [PIX_W-1:0]      pixel_value_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [PIX_W-1:0]      out_pixel_o,
  output logic                  end_of_frame_o
);

  logic [WID_W-1:0]    width_q;
  logic [HGT_W-1:0]    height_q;
  mode_e               mode_q;
  logic [COLX_W-1:0]   width_used;
  logic [ROWX_W-1:0]   height_used;
  logic                cfg_hit;

  logic [COL_W-1:0]    in_col_q, in_col_d;
  logic [ROW_W-1:0]    in_row_q, in_row_d;
  logic                done_q, done_d;
  logic [COL_W-1:0]    out_col_q, out_col_d;
  logic [ROW_W-1:0]    out_row_q, out_row_d;

  logic                accept;
  logic                is_pixel;
  logic                advance;
  logic                due;
  logic                emit;
  logic                out_last;
  logic [ROWX_W-1:0]   rx;
  logic [COLX_W-1:0]   cx;
  s1_req_t             req;

  logic                line_we;
  logic [COL_W-1:0]    line_waddr;
  logic [LINE_W-1:0]   line_wdata;
  logic [LINE_W-1:0]   line_rdata;
  logic                res_push;
  res_t                res;
  res_t                q_item;
  logic [OUTQ_PTR_W:0] q_level;

  // clamp frame size to the supported range
  always_comb begin
    width_used = COLX_W'(width_q);
    if (width_used < COLX_W'(MIN_DIM)) begin
      width_used = COLX_W'(MIN_DIM);
    end else if (width_used > COLX_W'(MAX_WIDTH)) begin
      width_used = COLX_W'(MAX_WIDTH);
    end
  end

  always_comb begin
    height_used = ROWX_W'(height_q);
    if (height_used < ROWX_W'(MIN_DIM)) begin
      height_used = ROWX_W'(MIN_DIM);
    end else if (height_used > ROWX_W'(MAX_HEIGHT)) begin
      height_used = ROWX_W'(MAX_HEIGHT);
    end
  end

  // configuration registers
  always_comb begin
    unique case (cfg_idx_e'(cfg_index_i))
      CFG_IMAGE_WIDTH:    cfg_hit = 1'b1;
      CFG_IMAGE_HEIGHT:   cfg_hit = 1'b1;
      CFG_OPERATION_MODE: cfg_hit = 1'b1;
      default:            cfg_hit = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WIDTH_RESET;
      height_q <= HEIGHT_RESET;
      mode_q   <= MODE_ERODE;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_IMAGE_WIDTH:    width_q  <= cfg_data_i[WID_W-1:0];
        CFG_IMAGE_HEIGHT:   height_q <= cfg_data_i[HGT_W-1:0];
        CFG_OPERATION_MODE: mode_q   <= mode_e'(cfg_data_i[0]);
        default: ;
      endcase
    end
  end

  // request decode
  assign accept   = in_valid_i && !in_stall_o;
  assign is_pixel = (action_e'(action_i) == ACT_PIXEL);
  assign advance  = accept && (is_pixel ? !done_q : done_q);
  assign due      = (in_row_q >= ROW_W'(2)) || ((in_row_q == ROW_W'(1)) && (in_col_q != '0));
  assign emit     = advance && (!is_pixel || due);

  // output position and neighborhood masks
  assign rx       = ROWX_W'(out_row_q);
  assign cx       = COLX_W'(out_col_q);
  assign out_last = (cx + COLX_W'(1) == width_used) && (rx + ROWX_W'(1) == height_used);

  always_comb begin
    req      = '0;
    req.adv  = advance;
    req.wr   = advance && is_pixel;
    req.fg   = is_pixel && (pixel_value_i != '0);
    req.addr = in_col_q;
    req.emit = emit;
    req.last = out_last;
    req.mode = mode_q;
    req.rin  = {(rx + ROWX_W'(1) < height_used), 1'b1, (rx != '0)};
    req.rint = {(rx + ROWX_W'(3) <= height_used),
                (rx >= ROWX_W'(1)) && (rx + ROWX_W'(2) <= height_used),
                (rx >= ROWX_W'(2)) && (rx + ROWX_W'(1) <= height_used)};
    req.cin  = {(cx + COLX_W'(1) < width_used), 1'b1, (cx != '0)};
    req.cint = {(cx + COLX_W'(3) <= width_used),
                (cx >= COLX_W'(1)) && (cx + COLX_W'(2) <= width_used),
                (cx >= COLX_W'(2)) && (cx + COLX_W'(1) <= width_used)};
  end

  // stream position counters
  always_comb begin
    in_col_d  = in_col_q;
    in_row_d  = in_row_q;
    done_d    = done_q;
    out_col_d = out_col_q;
    out_row_d = out_row_q;
    if (cfg_we_i && cfg_hit) begin
      in_col_d  = '0;
      in_row_d  = '0;
      done_d    = 1'b0;
      out_col_d = '0;
      out_row_d = '0;
    end else if (advance) begin
      // input side; drains keep stepping the column for the memory address
      if (COLX_W'(in_col_q) + COLX_W'(1) >= width_used) begin
        in_col_d = '0;
        if (is_pixel) begin
          if (ROWX_W'(in_row_q) + ROWX_W'(1) >= height_used) begin
            in_row_d = '0;
            done_d   = 1'b1;
          end else begin
            in_row_d = in_row_q + 1'b1;
          end
        end
      end else begin
        in_col_d = in_col_q + 1'b1;
      end
      // output side; the last result of a frame restarts the stream
      if (emit) begin
        if (out_last) begin
          in_col_d  = '0;
          in_row_d  = '0;
          done_d    = 1'b0;
          out_col_d = '0;
          out_row_d = '0;
        end else if (cx + COLX_W'(1) >= width_used) begin
          out_col_d = '0;
          out_row_d = out_row_q + 1'b1;
        end else begin
          out_col_d = out_col_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_col_q  <= '0;
      in_row_q  <= '0;
      done_q    <= 1'b0;
      out_col_q <= '0;
      out_row_q <= '0;
    end else begin
      in_col_q  <= in_col_d;
      in_row_q  <= in_row_d;
      done_q    <= done_d;
      out_col_q <= out_col_d;
      out_row_q <= out_row_d;
    end
  end

  // line memory: two previous rows per column
  bm3_ram #(
    .WIDTH (LINE_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (line_we),
    .waddr_i (line_waddr),
    .wdata_i (line_wdata),
    .re_i    (advance),
    .raddr_i (in_col_q),
    .rdata_o (line_rdata)
  );

  bm3_window u_window (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_i        (req),
    .line_rdata_i (line_rdata),
    .line_we_o    (line_we),
    .line_waddr_o (line_waddr),
    .line_wdata_o (line_wdata),
    .push_o       (res_push),
    .res_o        (res)
  );

  bm3_outq u_outq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_push),
    .item_i      (res),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .item_o      (q_item),
    .level_o     (q_level)
  );

  // back-pressure: room for the held results plus one in flight
  assign in_stall_o     = (q_level >= (OUTQ_PTR_W+1)'(2));
  assign out_pixel_o    = {PIX_W{q_item.fg}};
  assign end_of_frame_o = q_item.eof;

`ifndef ASSERT_OFF
  // the result queue never exceeds what back-pressure allows
  a_outq_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_level <= (OUTQ_PTR_W+1)'(OUTQ_DEPTH - 1))
    else $error("result queue overfilled");

  // write-back never hits the column being read in the same cycle
  a_line_no_collide: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (line_we && advance && !$past(cfg_we_i)) |-> (line_waddr != in_col_q))
    else $error("line memory read and write collide");

  // the last result of a frame returns the stream to its start
  a_frame_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && out_last) |=> (in_col_q == '0 && in_row_q == '0 && out_col_q == '0 &&
                            out_row_q == '0 && !done_q))
    else $error("stream position not cleared at frame end");
`endif

endmodule

FILE: sim/testbench.sv
// Self-checking testbench for binary_morphology_3x3_top (3x3 erosion / dilation).
// Depends on bm3_pkg and the block's RTL. It runs directed frames, frames at the
// largest sizes, then random small frames, checking every result (model or table).
module testbench;
  import bm3_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned HANG_LIMIT   = 2000;
  localparam int unsigned SETTLE_WAIT  = 8;
  localparam int unsigned RANDOM_ITEMS = 1800;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = 2'd3;
  localparam logic [PIX_W-1:0] PIX_FG = 8'hFF;
  localparam logic [PIX_W-1:0] PIX_BG = 8'h00;

  typedef struct packed {
    logic [PIX_W-1:0] pix;
    logic             eof;
  } px_res_t;

  typedef enum logic {ROW_ITEM, ROW_WRITE} row_kind_e;
  // How a request's result is found: from the model, none at all, or given in the row
  typedef enum logic [1:0] {CHK_MODEL, CHK_SILENT, CHK_GIVEN} check_e;

  typedef struct packed {
    row_kind_e             kind;
    logic [CFG_IDX_W-1:0]  reg_idx;
    logic [CFG_DATA_W-1:0] reg_data;
    action_e               act;
    logic [PIX_W-1:0]      pix;
    check_e                chk;
    logic [PIX_W-1:0]      exp_pix;
    logic                  exp_eof;
  } dir_row_t;

  // Directed frames: two requests at reset size, a 3x3 erosion frame of all foreground
  // (only the center survives), then a 3x3 dilation frame with a lone center pixel
  // (every result is 255). Early drains, drains after frame end and pixels after
  // the frame input are all dropped.
  localparam dir_row_t DIRECTED_ROWS [34] = '{
    '{ROW_ITEM,  CFG_IMAGE_WIDTH,    13'd0,    ACT_DRAIN, 8'h5A, CHK_SILENT, PIX_BG, 1'b0},
    '{ROW_ITEM,  CFG_IMAGE_WIDTH,    13'd0,    ACT_PIXEL, 8'hFF, CHK_SILENT, PIX_BG, 1'b0},
    '{ROW_WRITE, CFG_IMAGE_WIDTH,    13'h1003, ACT_PIXEL, 8'h00, CHK_SILENT, PIX_BG, 1'b0},
    '{ROW_WRITE, CFG_IMAGE_HEIGHT,   13'd2,    ACT_PIXEL, 8'h00, CHK_SILENT, PIX_BG, 1'b0},
    '{ROW_WRITE, CFG_OPERATION_MODE, 13'd0,    ACT_PIXEL, 8'h00, CHK_SILENT, PIX_BG, 1'b0},
    '{ROW_ITEM,  CFG_IMAGE_WIDTH,    13'd0,    ACT_PIXEL, 8'h01, CHK_SILENT, PIX_BG, 1'b0},
    '{ROW_ITEM,  CFG_IMAGE_WIDTH,    13'd0,    ACT_PIXEL, 8'h02, CHK_SILENT, PIX_BG, 1'b0},
    '{ROW_ITEM,  CFG_IMAGE_WIDTH,    13'd0,    ACT_PIXEL, 8'h04, CHK_SILENT, PIX_BG, 1'b0},
    '{ROW_ITEM,  CFG_IMAGE_WIDTH,    13'd0,    ACT_PIXEL, 8'h08, CHK_SILENT, PIX_BG, 1'b0},
    '{ROW_ITEM,  CFG_IMAGE_WIDTH,    13'd0,    ACT_PIXEL, 8'h10, CHK_GIVEN,  PIX_BG, 1'b0},
    '{ROW_ITEM,  CFG_IMAGE_WIDTH,    13'd0,    ACT_PIXEL, 8'h20, CHK_GIVEN,  PIX_BG, 1'b0},
    '{ROW_ITEM,  CFG_IMAGE_WIDTH,    13'd0,    ACT_PIXEL, 8'h40, CHK_GIVEN,  PIX_BG, 1'b0},
    '{ROW_ITEM,  CFG_IMAGE_WIDTH,    13'd0,    ACT_PIXEL, 8'h80, CHK_GIVEN,  PIX_BG, 1'b0},
    '{ROW_ITEM,  CFG_IMAGE_WIDTH,    13'd0,    ACT_PIXEL, 8'hFF, CHK_GIVEN,  PIX_FG, 1'b0},
    '{ROW_ITEM,  CFG_IMAGE_WIDTH,    13'd0,    ACT_DRAIN, 8'h00, CHK_GIVEN,  PIX_BG, 1'b0},
    '{ROW_ITEM,  CFG_IMAGE_WIDTH,    13'd0,    ACT_DRAIN, 8'hFF, CHK_GIVEN,  PIX_BG, 1'b0},
    '{ROW_ITEM,  CFG_IMAGE_WIDTH,    13'd0,    ACT_DRAIN, 8'h00, CHK_GIVEN,  PIX_BG, 1'b0},
    '{ROW_ITEM,  CFG_IMAGE_WIDTH,    13'd0,    ACT_DRAIN, 8'h00, CHK_GIVEN,  PIX_BG, 1'b1},
    '{ROW_ITEM,  CFG_IMAGE_WIDTH,    13'd0,    ACT_DRAIN, 8'h00, CHK_SILENT, PIX_BG, 1'b0},
    '{ROW_WRITE, CFG_OPERATION_MODE, 13'h1FFF, ACT_PIXEL, 8'h00, CHK_SILENT, PIX_BG, 1'b0},
    '{ROW_ITEM,  CFG_IMAGE_WIDTH,    13'd0,    ACT_PIXEL, 8'h00, CHK_SILENT, PIX_BG, 1'b0},
    '{ROW_ITEM,  CFG_IMAGE_WIDTH,    13'd0,    ACT_PIXEL, 8'h00, CHK_SILENT, PIX_BG, 1'b0},
    '{ROW_ITEM,  CFG_IMAGE_WIDTH,    13'd0,    ACT_PIXEL, 8'h00, CHK_SILENT, PIX_BG, 1'b0},
    '{ROW_ITEM,  CFG_IMAGE_WIDTH,    13'd0,    ACT_PIXEL, 8'h00, CHK_SILENT, PIX_BG, 1'b0},
    '{ROW_ITEM,  CFG_IMAGE_WIDTH,    13'd0,    ACT_PIXEL, 8'h80, CHK_GIVEN,  PIX_FG, 1'b0},
    '{ROW_ITEM,  CFG_IMAGE_WIDTH,    13'd0,    ACT_PIXEL, 8'h00, CHK_GIVEN,  PIX_FG, 1'b0},
    '{ROW_ITEM,  CFG_IMAGE_WIDTH,    13'd0,    ACT_PIXEL, 8'h00, CHK_GIVEN,  PIX_FG, 1'b0},
    '{ROW_ITEM,  CFG_IMAGE_WIDTH,    13'd0,    ACT_PIXEL, 8'h00, CHK_GIVEN,  PIX_FG, 1'b0},
    '{ROW_ITEM,  CFG_IMAGE_WIDTH,    13'd0,    ACT_PIXEL, 8'h00, CHK_GIVEN,  PIX_FG, 1'b0},
    '{ROW_ITEM,  CFG_IMAGE_WIDTH,    13'd0,    ACT_PIXEL, 8'h7F, CHK_SILENT, PIX_BG, 1'b0},
    '{ROW_ITEM,  CFG_IMAGE_WIDTH,    13'd0,    ACT_DRAIN, 8'h00, CHK_GIVEN,  PIX_FG, 1'b0},
    '{ROW_ITEM,  CFG_IMAGE_WIDTH,    13'd0,    ACT_DRAIN, 8'h00, CHK_GIVEN,  PIX_FG, 1'b0},
    '{ROW_ITEM,  CFG_IMAGE_WIDTH,    13'd0,    ACT_DRAIN, 8'h00, CHK_GIVEN,  PIX_FG, 1'b0},
    '{ROW_ITEM,  CFG_IMAGE_WIDTH,    13'd0,    ACT_DRAIN, 8'h00, CHK_GIVEN,  PIX_FG, 1'b1}
  };

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  logic                  in_valid_i;
  logic                  in_stall_o;
  logic                  action_i;
  logic [PIX_W-1:0]      pixel_value_i;
  logic                  out_valid_o;
  logic                  out_stall_i;
  logic [PIX_W-1:0]      out_pixel_o;
  logic                  end_of_frame_o;

  binary_morphology_3x3_top i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .action_i       (action_i),
    .pixel_value_i  (pixel_value_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .out_pixel_o    (out_pixel_o),
    .end_of_frame_o (end_of_frame_o)
  );

  // Model state: registers, three rows of foreground bits, stream position
  logic [WID_W-1:0] reg_width;
  logic [HGT_W-1:0] reg_height;
  mode_e            reg_mode;
  bit               line_bits [3][MAX_WIDTH];
  int               in_row, in_col, out_row, out_col;
  bit               in_complete;

  px_res_t     due_pixels [$];
  int unsigned used_items, results_seen, frames_done, writes_done, mismatches;
  int unsigned idle_cycles;
  bit          steady_sender;

  function automatic int frame_width();
    if (reg_width < MIN_DIM) return MIN_DIM;
    if (reg_width > MAX_WIDTH) return MAX_WIDTH;
    return int'(reg_width);
  endfunction

  function automatic int frame_height();
    if (reg_height < MIN_DIM) return MIN_DIM;
    if (reg_height > MAX_HEIGHT) return MAX_HEIGHT;
    return int'(reg_height);
  endfunction

  function automatic void restart_position();
    in_row      = 0;
    in_col      = 0;
    out_row     = 0;
    out_col     = 0;
    in_complete = 1'b0;
  endfunction

  function automatic void apply_reg_write(logic [CFG_IDX_W-1:0] idx,
                                          logic [CFG_DATA_W-1:0] data);
    case (idx)
      CFG_IMAGE_WIDTH:    reg_width = data[WID_W-1:0];
      CFG_IMAGE_HEIGHT:   reg_height = data[HGT_W-1:0];
      CFG_OPERATION_MODE: reg_mode = mode_e'(data[0]);
      default:            return;
    endcase
    restart_position();
  endfunction

  // Result for the pixel at the output position, then step that position
  function automatic px_res_t morph_result();
    int      w, h, r, c, dr, dc;
    bit      fg, all_fg, any_core, center_core, last;
    px_res_t res;
    w        = frame_width();
    h        = frame_height();
    all_fg   = 1'b1;
    any_core = 1'b0;
    for (dr = -1; dr <= 1; dr++) begin
      for (dc = -1; dc <= 1; dc++) begin
        r  = out_row + dr;
        c  = out_col + dc;
        fg = 1'b0;
        if (r >= 0 && r < h && c >= 0 && c < w) fg = line_bits[r % 3][c];
        if (!fg) all_fg = 1'b0;
        if (fg && r >= 1 && r <= h - 2 && c >= 1 && c <= w - 2) any_core = 1'b1;
      end
    end
    center_core = out_row >= 1 && out_row <= h - 2 && out_col >= 1 && out_col <= w - 2;
    if (reg_mode == MODE_ERODE) res.pix = (center_core && all_fg) ? PIX_FG : PIX_BG;
    else res.pix = any_core ? PIX_FG : PIX_BG;
    last    = out_row == h - 1 && out_col == w - 1;
    res.eof = last;
    if (last) begin
      restart_position();
    end else begin
      out_col++;
      if (out_col >= w) begin
        out_col = 0;
        out_row++;
      end
    end
    return res;
  endfunction

  // One request into the model: was it used, and did it produce a result
  function automatic void morph_item(input action_e act, input logic [PIX_W-1:0] pix,
                                     output bit used, output bit has_res,
                                     output px_res_t res);
    int w, h;
    bit due;
    w       = frame_width();
    h       = frame_height();
    used    = 1'b0;
    has_res = 1'b0;
    res     = '0;
    if (act == ACT_PIXEL) begin
      if (in_complete) return;
      line_bits[in_row % 3][in_col] = (pix != 0);
      due = in_row >= 2 || (in_row == 1 && in_col >= 1);
      in_col++;
      if (in_col >= w) begin
        in_col = 0;
        in_row++;
        if (in_row >= h) begin
          in_row      = 0;
          in_complete = 1'b1;
        end
      end
      used = 1'b1;
      if (due) begin
        res     = morph_result();
        has_res = 1'b1;
      end
    end else if (in_complete) begin
      used    = 1'b1;
      res     = morph_result();
      has_res = 1'b1;
    end
  endfunction

  function automatic int unsigned sender_gap();
    int unsigned p;
    if (steady_sender) return 0;
    p = $urandom_range(0, 99);
    if (p < 60) return 0;
    if (p < 88) return $urandom_range(1, 3);
    if (p < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Issue one request and record what it should produce
  task automatic send(action_e act, logic [PIX_W-1:0] pix, check_e chk, px_res_t given);
    bit          used, has_res;
    px_res_t     res;
    int unsigned gap;
    in_valid_i    <= 1'b1;
    action_i      <= act;
    pixel_value_i <= pix;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    morph_item(act, pix, used, has_res, res);
    if (used) used_items++;
    if (chk == CHK_MODEL && has_res) due_pixels.push_back(res);
    if (chk == CHK_GIVEN) due_pixels.push_back(given);
    gap = sender_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Hold off until every result is in and the pipeline has settled
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (due_pixels.size() != 0) @(posedge clk_i);
    repeat (SETTLE_WAIT) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    wait_drained();
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    apply_reg_write(idx, data);
    cfg_we_i <= 1'b0;
    writes_done++;
  endtask

  // One frame in raster order plus drains if not cut short; dropped requests mixed in
  task automatic run_frame(int unsigned fg_pct, bit cut_short, bit pause_mid);
    int unsigned w, h, n, k;
    w = frame_width();
    h = frame_height();
    n = w * h;
    if (cut_short) n = $urandom_range(1, n - 1);
    for (k = 0; k < n; k++) begin
      if ($urandom_range(0, 99) < 3) send(ACT_DRAIN, 8'($urandom), CHK_MODEL, '0);
      // mid-frame pause; the spare register index must not move the stream
      if (pause_mid && k == n / 2) write_reg(CFG_SPARE_IDX, 13'($urandom));
      send(ACT_PIXEL, ($urandom_range(0, 99) < fg_pct) ? 8'($urandom_range(1, 255)) : PIX_BG,
           CHK_MODEL, '0);
    end
    if (!cut_short) begin
      for (k = 0; k <= w; k++) begin
        if ($urandom_range(0, 99) < 8) send(ACT_PIXEL, 8'($urandom), CHK_MODEL, '0);
        send(ACT_DRAIN, 8'($urandom), CHK_MODEL, '0);
      end
      frames_done++;
    end
  endtask

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Receiver: free-running stretches, short random stalls, a few long stalls
  initial begin
    int unsigned pick;
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      pick = $urandom_range(0, 99);
      if (pick < 25) begin
        out_stall_i <= 1'b0;
        repeat ($urandom_range(30, 200)) @(posedge clk_i);
      end else if (pick < 30) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(20, 60)) @(posedge clk_i);
      end else begin
        out_stall_i <= ($urandom_range(0, 99) < 35);
        repeat ($urandom_range(1, 3)) @(posedge clk_i);
      end
    end
  end

  // Result check against the oldest pending pixel
  always @(posedge clk_i) begin
    px_res_t exp_res;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_seen++;
      if (due_pixels.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected result pixel=%0d eof=%0b", $time, out_pixel_o,
                   end_of_frame_o);
      end else begin
        exp_res = due_pixels.pop_front();
        if (out_pixel_o !== exp_res.pix || end_of_frame_o !== exp_res.eof) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: result mismatch pixel exp=%0d got=%0d, eof exp=%0b got=%0b",
                     $time, exp_res.pix, out_pixel_o, exp_res.eof, end_of_frame_o);
        end
      end
    end
  end

  // Watchdog on cycles without any handshake
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= HANG_LIMIT) begin
        $display("watchdog: no handshake for %0d cycles, %0d results outstanding",
                 idle_cycles, due_pixels.size());
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // Stimulus
  initial begin
    int unsigned base_items, frame_idx, fg_pct;
    bit          need_write, cut;
    dir_row_t    row;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_index_i   = '0;
    cfg_data_i    = '0;
    in_valid_i    = 1'b0;
    action_i      = ACT_PIXEL;
    pixel_value_i = '0;
    steady_sender = 1'b0;
    reg_width     = WIDTH_RESET;
    reg_height    = HEIGHT_RESET;
    reg_mode      = MODE_ERODE;
    restart_position();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table
    foreach (DIRECTED_ROWS[i]) begin
      row = DIRECTED_ROWS[i];
      if (row.kind == ROW_WRITE) write_reg(row.reg_idx, row.reg_data);
      else send(row.act, row.pix, row.chk, '{pix: row.exp_pix, eof: row.exp_eof});
    end

    // largest width (clamped from 4095) with the smallest height, dense erosion
    write_reg(CFG_IMAGE_WIDTH, 13'h0FFF);
    write_reg(CFG_IMAGE_HEIGHT, 13'd0);
    write_reg(CFG_OPERATION_MODE, 13'(MODE_ERODE));
    run_frame(95, 1'b0, 1'b0);
    // largest height (clamped from 8191) with the smallest width, sparse dilation
    write_reg(CFG_IMAGE_WIDTH, 13'd2);
    write_reg(CFG_IMAGE_HEIGHT, 13'h1FFF);
    write_reg(CFG_OPERATION_MODE, 13'(MODE_DILATE));
    run_frame(5, 1'b0, 1'b0);

    // random small frames; some cut short, some back to back without a write
    base_items = used_items;
    need_write = 1'b1;
    frame_idx  = 0;
    while (used_items - base_items < RANDOM_ITEMS) begin
      steady_sender = ($urandom_range(0, 3) == 0);
      if (need_write || $urandom_range(0, 99) < 70) begin
        if (need_write || $urandom_range(0, 4) != 0) begin
          case ($urandom_range(0, 9))
            0:       write_reg(CFG_IMAGE_WIDTH, 13'($urandom_range(0, 2)));
            1:       write_reg(CFG_IMAGE_WIDTH, 13'h1000 | 13'($urandom_range(3, 9)));
            2:       write_reg(CFG_IMAGE_WIDTH, 13'($urandom_range(11, 40)));
            default: write_reg(CFG_IMAGE_WIDTH, 13'($urandom_range(3, 10)));
          endcase
          case ($urandom_range(0, 9))
            0:       write_reg(CFG_IMAGE_HEIGHT, 13'($urandom_range(0, 2)));
            1:       write_reg(CFG_IMAGE_HEIGHT, 13'($urandom_range(9, 16)));
            default: write_reg(CFG_IMAGE_HEIGHT, 13'($urandom_range(3, 8)));
          endcase
        end
        write_reg(CFG_OPERATION_MODE, 13'($urandom));
      end
      case ($urandom_range(0, 3))
        0:       fg_pct = 15;
        1:       fg_pct = 50;
        2:       fg_pct = 85;
        default: fg_pct = 97;
      endcase
      cut = ($urandom_range(0, 9) == 0);
      run_frame(fg_pct, cut, frame_idx == 0 || $urandom_range(0, 9) == 0);
      need_write = cut;
      // drain after the frame has closed is dropped
      if (!cut && $urandom_range(0, 9) == 0) send(ACT_DRAIN, 8'($urandom), CHK_MODEL, '0);
      frame_idx++;
    end

    wait_drained();
    $display("Covered %0d complete frames and %0d register writes, sizes 3x3 up to 2048x3",
             frames_done, writes_done);
    $display("and 3x4096; %0d requests used, %0d results checked, %0d mismatches",
             used_items, results_seen, mismatches);
    if (mismatches == 0 && due_pixels.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

FILE: binary_morphology_3x3_top.f
hdl/bm3_pkg.sv
hdl/bm3_ram.sv
hdl/bm3_window.sv
hdl/bm3_outq.sv
hdl/binary_morphology_3x3_top.sv
sim/testbench.sv
